// ===== rtl/tbw_pkg.sv =====
package tbw_pkg;

	localparam int GRID_SPAN_DEF   = 32;
	localparam int SIZE_POWER_DEF  = 5;
	localparam int MAX_LOD_DEF     = 10;
	localparam int STACK_DEPTH_DEF = 12;

	localparam int COORD_W = 8;
	localparam int VTX_W   = 11;
	localparam int ORI_W   = 3;
	localparam int DEP_W   = 4;
	localparam int LOD_W   = 5;
	localparam int ENTRY_W = 24;
	localparam int MAX_TRI = 5;
	localparam int CNT_W   = 3;

	localparam logic [ORI_W-1:0] OR_L  = 3'd0;
	localparam logic [ORI_W-1:0] OR_R  = 3'd1;
	localparam logic [ORI_W-1:0] OR_LT = 3'd2;
	localparam logic [ORI_W-1:0] OR_LB = 3'd3;
	localparam logic [ORI_W-1:0] OR_T  = 3'd4;
	localparam logic [ORI_W-1:0] OR_B  = 3'd5;
	localparam logic [ORI_W-1:0] OR_RB = 3'd6;
	localparam logic [ORI_W-1:0] OR_RT = 3'd7;

	typedef struct packed {
		logic [0:0]         pad;
		logic [DEP_W-1:0]   depth;
		logic [ORI_W-1:0]   ori;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} task_t;

	typedef struct packed {
		logic [VTX_W-1:0] x;
		logic [VTX_W-1:0] y;
	} pt_t;

	typedef struct packed {
		pt_t a;
		pt_t b;
		pt_t c;
	} tri_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		tri_t [MAX_TRI-1:0] tris;
	} leaf_t;

endpackage

// ===== rtl/tbw_stack_mem.sv =====
module tbw_stack_mem #(
	parameter int DEPTH = tbw_pkg::STACK_DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [tbw_pkg::ENTRY_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [tbw_pkg::ENTRY_W-1:0] rdata
);

	logic [tbw_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tbw_leaf.sv =====
module tbw_leaf #(
	parameter int GRID_SPAN = tbw_pkg::GRID_SPAN_DEF
) (
	input  logic [tbw_pkg::COORD_W-1:0] x,
	input  logic [tbw_pkg::COORD_W-1:0] y,
	input  logic [tbw_pkg::ORI_W-1:0]   ori,
	input  logic [tbw_pkg::COORD_W-1:0] inc,
	input  logic [3:0]                  flags,
	output tbw_pkg::leaf_t              leaf
);

	localparam int VW = tbw_pkg::VTX_W;
	localparam logic [VW-1:0] PS = VW'(GRID_SPAN);

	logic [VW-1:0] X, Y, I, H;
	logic xi, xd, yi, yd;

	function automatic tbw_pkg::pt_t p(input logic [VW-1:0] px, input logic [VW-1:0] py);
		tbw_pkg::pt_t r;
		r.x = px;
		r.y = py;
		return r;
	endfunction

	function automatic tbw_pkg::tri_t t3(input tbw_pkg::pt_t a, input tbw_pkg::pt_t b,
			input tbw_pkg::pt_t c);
		tbw_pkg::tri_t r;
		r.a = a;
		r.b = b;
		r.c = c;
		return r;
	endfunction

	always_comb begin
		logic [tbw_pkg::CNT_W-1:0] n;
		X = VW'(x);
		Y = VW'(y);
		I = VW'(inc);
		H = VW'(inc >> 1);
		xi = flags[0];
		xd = flags[1];
		yi = flags[2];
		yd = flags[3];
		n = '0;
		leaf.tris = '0;
		unique case (ori)
			tbw_pkg::OR_L: begin
				if (X + I == PS && xi) begin
					leaf.tris[n] = t3(p(X+I, Y), p(X, Y), p(X+I, Y-I)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X+I, Y), p(X+I, Y+I), p(X, Y)); n = n + 1'b1;
				end
				leaf.tris[n] = t3(p(X, Y), p(X+I, Y-I), p(X+I, Y+I)); n = n + 1'b1;
			end
			tbw_pkg::OR_R: begin
				if (X - I == '0 && xd) begin
					leaf.tris[n] = t3(p(X-I, Y+I), p(X-I, Y), p(X, Y)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X, Y), p(X-I, Y), p(X-I, Y-I)); n = n + 1'b1;
				end
				leaf.tris[n] = t3(p(X, Y), p(X-I, Y+I), p(X-I, Y-I)); n = n + 1'b1;
			end
			tbw_pkg::OR_LT: begin
				leaf.tris[n] = t3(p(X, Y), p(X+I, Y), p(X, Y+I)); n = n + 1'b1;
				if (Y == '0 && yd) begin
					leaf.tris[n] = t3(p(X, Y), p(X+H, Y), p(X+H, Y+H)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X+I, Y), p(X+H, Y+H), p(X+H, Y)); n = n + 1'b1;
				end
				if (X == '0 && xd) begin
					leaf.tris[n] = t3(p(X, Y), p(X+H, Y+H), p(X, Y+H)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X+H, Y+H), p(X, Y+I), p(X, Y+H)); n = n + 1'b1;
				end
			end
			tbw_pkg::OR_LB: begin
				leaf.tris[n] = t3(p(X, Y), p(X, Y-I), p(X+I, Y)); n = n + 1'b1;
				if (X == '0 && xd) begin
					leaf.tris[n] = t3(p(X, Y-H), p(X, Y-I), p(X+H, Y-H)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X, Y), p(X, Y-H), p(X+H, Y-H)); n = n + 1'b1;
				end
				if (Y == PS && yi) begin
					leaf.tris[n] = t3(p(X, Y), p(X+H, Y-H), p(X+H, Y)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X+H, Y), p(X+H, Y-H), p(X+I, Y)); n = n + 1'b1;
				end
			end
			tbw_pkg::OR_T: begin
				if (Y + I == PS && yi) begin
					leaf.tris[n] = t3(p(X, Y+I), p(X-I, Y+I), p(X, Y)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X, Y+I), p(X, Y), p(X+I, Y+I)); n = n + 1'b1;
				end
				leaf.tris[n] = t3(p(X, Y), p(X+I, Y+I), p(X-I, Y+I)); n = n + 1'b1;
			end
			tbw_pkg::OR_B: begin
				if (Y - I == '0 && yd) begin
					leaf.tris[n] = t3(p(X, Y-I), p(X, Y), p(X-I, Y-I)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X, Y-I), p(X+I, Y-I), p(X, Y)); n = n + 1'b1;
				end
				leaf.tris[n] = t3(p(X, Y), p(X-I, Y-I), p(X+I, Y-I)); n = n + 1'b1;
			end
			tbw_pkg::OR_RB: begin
				leaf.tris[n] = t3(p(X, Y), p(X-I, Y), p(X, Y-I)); n = n + 1'b1;
				if (Y == PS && yi) begin
					leaf.tris[n] = t3(p(X, Y), p(X-H, Y), p(X-H, Y-H)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X-I, Y), p(X-H, Y-H), p(X-H, Y)); n = n + 1'b1;
				end
				if (X == PS && xi) begin
					leaf.tris[n] = t3(p(X, Y), p(X-H, Y-H), p(X, Y-H)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X-H, Y-H), p(X, Y-I), p(X, Y-H)); n = n + 1'b1;
				end
			end
			default: begin
				leaf.tris[n] = t3(p(X, Y), p(X, Y+I), p(X-I, Y)); n = n + 1'b1;
				if (Y == '0 && yd) begin
					leaf.tris[n] = t3(p(X, Y), p(X-H, Y+H), p(X-H, Y)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X-I, Y), p(X-H, Y), p(X-H, Y+H)); n = n + 1'b1;
				end
				if (X == PS && xi) begin
					leaf.tris[n] = t3(p(X, Y), p(X, Y+H), p(X-H, Y+H)); n = n + 1'b1;
					leaf.tris[n] = t3(p(X-H, Y+H), p(X, Y+H), p(X, Y+I)); n = n + 1'b1;
				end
			end
		endcase
		leaf.cnt = n;
	end

endmodule

// ===== rtl/terrain_bintree_index_walker.sv =====
// Binary triangle tree index walker for one square terrain patch. A start
// transaction (mode 0) loads the border flags and, when the clamped level
// changes, reseeds the task stack with two root triangles; it always answers
// with one empty result. Each advance transaction (mode 1) walks the task
// stack, held in a synchronous single-port-write memory, until it reaches a
// leaf, then returns that leaf's triangle plus up to four flange triangles;
// on an empty stack it answers with one empty result. One transaction is
// processed at a time. A split task is popped, decided and its second
// child pushed (POP, DECIDE, PUSH2); leaf triangles go out one by one.
module terrain_bintree_index_walker #(
	parameter int GRID_SPAN   = tbw_pkg::GRID_SPAN_DEF,
	parameter int SIZE_POWER  = tbw_pkg::SIZE_POWER_DEF,
	parameter int MAX_LOD     = tbw_pkg::MAX_LOD_DEF,
	parameter int STACK_DEPTH = tbw_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [3:0]  lod_request,
	input  logic        edge_x_high,
	input  logic        edge_x_low,
	input  logic        edge_y_high,
	input  logic        edge_y_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] corner_a,
	output logic [10:0] corner_b,
	output logic [10:0] corner_c,
	output logic        has_triangle,
	output logic        leaf_last,
	output logic        all_done
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int CW = tbw_pkg::COORD_W;
	localparam int VW = tbw_pkg::VTX_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);
	localparam logic [VW-1:0] ROW = VW'(GRID_SPAN + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ROOT2  = 3'd1;
	localparam logic [2:0] S_REPLY  = 3'd2;
	localparam logic [2:0] S_POP    = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_PUSH2  = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]                  state_q;
	logic [LW-1:0]               level_q;
	logic [tbw_pkg::LOD_W-1:0]   lod_q;
	logic [3:0]                  flags_q;
	tbw_pkg::task_t              child2_q;
	tbw_pkg::leaf_t              leaf_q;
	logic [tbw_pkg::CNT_W-1:0]   k_q;

	logic                        we, re;
	logic [AW-1:0]               waddr, raddr;
	logic [tbw_pkg::ENTRY_W-1:0] wdata, rdata;

	tbw_pkg::task_t              top, c1, c2, root1, root2;
	logic [tbw_pkg::LOD_W-1:0]   lod_clamp;
	logic [3:0]                  lvl;
	logic [CW-1:0]               inc, h;
	logic [tbw_pkg::DEP_W-1:0]   dn;
	tbw_pkg::leaf_t              leaf_c;
	tbw_pkg::tri_t               cur;
	logic                        ld, acc, fire;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;
	assign ld = !out_valid || !out_stall;
	assign fire = ((state_q == S_REPLY) || (state_q == S_EMIT)) && ld;

	assign top = tbw_pkg::task_t'(rdata);
	assign lod_clamp = ({1'b0, lod_request} > tbw_pkg::LOD_W'(MAX_LOD)) ?
		tbw_pkg::LOD_W'(MAX_LOD) : {1'b0, lod_request};
	assign lvl = 4'(({1'b0, top.depth} + 5'd1) >> 1);
	assign inc = (32'(lvl) <= SIZE_POWER) ? (CW'(1) << (SIZE_POWER - 32'(lvl))) : '0;
	assign h = inc >> 1;
	assign dn = top.depth + 1'b1;

	always_comb begin
		root1 = '0;
		root1.x = CW'(GRID_SPAN);
		root1.y = CW'(GRID_SPAN);
		root1.ori = tbw_pkg::OR_RB;
		root2 = '0;
		root2.ori = tbw_pkg::OR_LT;
		c1 = '0;
		c1.depth = dn;
		c2 = '0;
		c2.depth = dn;
		unique case (top.ori)
			tbw_pkg::OR_L: begin
				c1.x = top.x + inc; c1.y = top.y; c1.ori = tbw_pkg::OR_RT;
				c2.ori = tbw_pkg::OR_RB;
			end
			tbw_pkg::OR_R: begin
				c1.x = top.x - inc; c1.y = top.y; c1.ori = tbw_pkg::OR_LT;
				c2.ori = tbw_pkg::OR_LB;
			end
			tbw_pkg::OR_LT: begin
				c1.x = top.x + h; c1.y = top.y + h; c1.ori = tbw_pkg::OR_B;
				c2.ori = tbw_pkg::OR_R;
			end
			tbw_pkg::OR_LB: begin
				c1.x = top.x + h; c1.y = top.y - h; c1.ori = tbw_pkg::OR_T;
				c2.ori = tbw_pkg::OR_R;
			end
			tbw_pkg::OR_T: begin
				c1.x = top.x; c1.y = top.y + inc; c1.ori = tbw_pkg::OR_LB;
				c2.ori = tbw_pkg::OR_RB;
			end
			tbw_pkg::OR_B: begin
				c1.x = top.x; c1.y = top.y - inc; c1.ori = tbw_pkg::OR_LT;
				c2.ori = tbw_pkg::OR_RT;
			end
			tbw_pkg::OR_RB: begin
				c1.x = top.x - h; c1.y = top.y - h; c1.ori = tbw_pkg::OR_T;
				c2.ori = tbw_pkg::OR_L;
			end
			default: begin
				c1.x = top.x - h; c1.y = top.y + h; c1.ori = tbw_pkg::OR_L;
				c2.ori = tbw_pkg::OR_B;
			end
		endcase
		c2.x = c1.x;
		c2.y = c1.y;
	end

	always_comb begin
		we = 1'b0;
		waddr = level_q[AW-1:0];
		wdata = '0;
		re = 1'b0;
		raddr = AW'(level_q - 1'b1);
		unique case (state_q)
			S_IDLE: begin
				if (acc && !mode && lod_clamp != lod_q) begin
					we = 1'b1;
					waddr = '0;
					wdata = root1;
				end
				re = acc && mode && level_q != '0;
			end
			S_ROOT2: begin
				we = 1'b1;
				waddr = AW'(1);
				wdata = root2;
			end
			S_POP: re = (level_q != '0);
			S_DECIDE: begin
				we = ({1'b0, top.depth} < lod_q) && (level_q < DEPTH_L);
				wdata = c1;
			end
			S_PUSH2: begin
				we = (level_q < DEPTH_L);
				wdata = child2_q;
			end
			default: ;
		endcase
	end

	tbw_stack_mem #(.DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	tbw_leaf #(.GRID_SPAN(GRID_SPAN)) u_leaf (
		.x     (top.x),
		.y     (top.y),
		.ori   (top.ori),
		.inc   (inc),
		.flags (flags_q),
		.leaf  (leaf_c)
	);

	assign cur = leaf_q.tris[k_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			level_q <= '0;
			lod_q <= '1;
			flags_q <= '0;
			k_q <= '0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= fire || (out_valid && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (!mode) begin
							flags_q <= {edge_y_low, edge_y_high, edge_x_low, edge_x_high};
							if (lod_clamp != lod_q) begin
								lod_q <= lod_clamp;
								level_q <= LW'(1);
								state_q <= S_ROOT2;
							end else begin
								state_q <= S_REPLY;
							end
						end else if (level_q == '0) begin
							state_q <= S_REPLY;
						end else begin
							level_q <= level_q - 1'b1;
							state_q <= S_DECIDE;
						end
					end
				end
				S_ROOT2: begin
					level_q <= LW'(2);
					state_q <= S_REPLY;
				end
				S_POP: begin
					if (level_q == '0) begin
						state_q <= S_REPLY;
					end else begin
						level_q <= level_q - 1'b1;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if ({1'b0, top.depth} < lod_q) begin
						if (level_q < DEPTH_L) begin
							level_q <= level_q + 1'b1;
						end
						child2_q <= c2;
						state_q <= S_PUSH2;
					end else begin
						leaf_q <= leaf_c;
						k_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_PUSH2: begin
					if (level_q < DEPTH_L) begin
						level_q <= level_q + 1'b1;
					end
					state_q <= S_POP;
				end
				S_REPLY: begin
					if (ld) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (ld) begin
						if (k_q == leaf_q.cnt - 1'b1) begin
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REPLY && ld) begin
			corner_a <= '0;
			corner_b <= '0;
			corner_c <= '0;
			has_triangle <= 1'b0;
			leaf_last <= 1'b1;
			all_done <= (level_q == '0);
		end else if (state_q == S_EMIT && ld) begin
			corner_a <= VW'(cur.a.x * ROW + cur.a.y);
			corner_b <= VW'(cur.b.x * ROW + cur.b.y);
			corner_c <= VW'(cur.c.x * ROW + cur.c.y);
			has_triangle <= 1'b1;
			leaf_last <= (k_q == leaf_q.cnt - 1'b1);
			all_done <= (level_q == '0);
		end
	end

endmodule
